// ===== sv/ptt_pkg.sv =====
// Shared codes, widths and types of the periodic task timer table.
package ptt_pkg;

    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int DATA_W      = 16;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RUN      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_TIME = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IN_USE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_RUN,
        S_FLUSH
    } state_t;

endpackage

// ===== sv/ptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/periodic_task_timer_table_top.sv =====
// Periodic task timer table: top level with scan sequencer and slot memories.
//
//  channel   signals                                          handshake
//  -------   ----------------------------------------------   -------------------------------
//  command   action slot initial_delay period task_tag         taken when start && !busy
//            new_time
//  result    status fired_valid fired_slot fired_tag           one-cycle pulse per result, result_valid
//            time_now last
//
//  Add, remove, set time and unused actions answer in the cycle after acceptance;
//  busy stays low, so a new item may follow in the very next cycle.
//  A tick sweeps the countdown memory once and answers once the last slot is
//  processed. A run pass sweeps the reload/tag memory and may stop early at
//  the result limit; dispatch results stream out while the sweep goes on. The
//  single read port of each memory reads one slot a cycle during a sweep.
//  Reset (rst_n low, asynchronous) frees every slot and clears the time count.
//  The receiver cannot stall; each result is shown for exactly one cycle.
module periodic_task_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ptt_pkg::ACTION_W-1:0]   action,
    input  logic [ptt_pkg::SLOT_W-1:0]     slot,
    input  logic [ptt_pkg::DATA_W-1:0]     initial_delay,
    input  logic [ptt_pkg::DATA_W-1:0]     period,
    input  logic [ptt_pkg::DATA_W-1:0]     task_tag,
    input  logic [ptt_pkg::TIME_W-1:0]     new_time,
    output logic                           result_valid,
    output logic [ptt_pkg::STATUS_W-1:0]   status,
    output logic                           fired_valid,
    output logic [ptt_pkg::SLOT_W-1:0]     fired_slot,
    output logic [ptt_pkg::DATA_W-1:0]     fired_tag,
    output logic [ptt_pkg::TIME_W-1:0]     time_now,
    output logic                           last
);

    import ptt_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // FSM and sweep control
    state_t            state_reg, state_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic              scan_done_reg, scan_done_next;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_end_reg;

    // Per-slot flags in flip-flops; the wide per-slot fields live in memory
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [SLOTS-1:0]  pending_reg, pending_next;
    logic [TIME_W-1:0] time_reg, time_next;

    // Dispatch count and the one-deep hold stage that lets us flag the last result
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hold_vld_reg, hold_vld_next;
    logic [SLOT_W-1:0] hold_slot_reg, hold_slot_next;
    logic [DATA_W-1:0] hold_tag_reg, hold_tag_next;

    // Result register
    logic                res_vld_reg, res_vld_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                fv_reg, fv_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [DATA_W-1:0]   ftag_reg, ftag_next;
    logic                last_reg, last_next;

    // Memory ports
    logic                  cd_we;
    logic [IW-1:0]         cd_waddr;
    logic [DATA_W-1:0]     cd_wdata;
    logic [DATA_W-1:0]     cd_rdata;
    logic                  rt_we;
    logic [2*DATA_W-1:0]   rt_rdata;

    // Datapath helpers
    logic              accept;
    logic              issue;
    logic [SW-1:0]     slot_ext;
    logic [IW-1:0]     slot_idx;
    logic              slot_in_range;
    logic [SW-1:0]     rd_idx_ext;
    logic [SLOT_W-1:0] rd_slot4;
    logic [DATA_W-1:0] rl_data;
    logic [DATA_W-1:0] tg_data;
    logic              tick_proc;
    logic              run_proc;
    logic              tick_dec;
    logic              run_hit;
    logic              cnt_full;

    assign accept        = start && !busy;
    assign busy          = (state_reg != S_IDLE);
    assign issue         = ((state_reg == S_TICK) || (state_reg == S_RUN)) && !scan_done_reg;
    assign slot_ext      = SW'(slot);
    assign slot_idx      = slot_ext[IW-1:0];
    assign slot_in_range = (32'(slot) < 32'(SLOTS));
    assign rd_idx_ext    = SW'(rd_idx_reg);
    assign rd_slot4      = rd_idx_ext[SLOT_W-1:0];
    assign rl_data       = rt_rdata[2*DATA_W-1:DATA_W];
    assign tg_data       = rt_rdata[DATA_W-1:0];

    assign tick_proc = (state_reg == S_TICK) && rd_vld_reg;
    assign run_proc  = (state_reg == S_RUN) && rd_vld_reg;
    assign tick_dec  = tick_proc && active_reg[rd_idx_reg] && (cd_rdata != '0);
    assign run_hit   = run_proc && active_reg[rd_idx_reg] && pending_reg[rd_idx_reg];
    assign cnt_full  = run_hit && (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // Countdown per slot
    ptt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_cd_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (cd_waddr),
        .wdata (cd_wdata),
        .raddr (scan_reg),
        .rdata (cd_rdata)
    );

    // Reload period and tag per slot, written only by add
    ptt_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (SLOTS)
    ) u_rt_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (slot_idx),
        .wdata ({period, task_tag}),
        .raddr (scan_reg),
        .rdata (rt_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if (action == ACT_RUN)
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_TICK:
            begin
                if (tick_proc && rd_end_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (run_proc && (rd_end_reg || cnt_full))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        scan_next      = issue ? scan_reg + 1'b1 : scan_reg;
        scan_done_next = scan_done_reg || (issue && (scan_reg == LAST_IDX));
        active_next    = active_reg;
        pending_next   = pending_reg;
        time_next      = time_reg;
        cnt_next       = cnt_reg;
        hold_vld_next  = hold_vld_reg;
        hold_slot_next = hold_slot_reg;
        hold_tag_next  = hold_tag_reg;
        res_vld_next   = 1'b0;
        status_next    = ST_OK;
        fv_next        = 1'b0;
        fslot_next     = '0;
        ftag_next      = '0;
        last_next      = 1'b1;
        cd_we          = 1'b0;
        cd_waddr       = rd_idx_reg;
        cd_wdata       = cd_rdata - 1'b1;
        rt_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next      = '0;
                    scan_done_next = 1'b0;
                    cnt_next       = '0;
                    hold_vld_next  = 1'b0;
                    res_vld_next   = 1'b1;
                    case (action)
                        ACT_TICK:
                        begin
                            // Result follows the sweep
                            time_next    = time_reg + 1'b1;
                            res_vld_next = 1'b0;
                        end
                        ACT_RUN:
                        begin
                            res_vld_next = 1'b0;
                        end
                        ACT_ADD:
                        begin
                            if (!slot_in_range || active_reg[slot_idx])
                            begin
                                status_next = ST_IN_USE;
                            end
                            else
                            begin
                                active_next[slot_idx]  = 1'b1;
                                pending_next[slot_idx] = 1'b0;
                                cd_we                  = 1'b1;
                                cd_waddr               = slot_idx;
                                cd_wdata               = initial_delay;
                                rt_we                  = 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!slot_in_range || !active_reg[slot_idx])
                            begin
                                status_next = ST_NOT_USED;
                            end
                            else
                            begin
                                active_next[slot_idx]  = 1'b0;
                                pending_next[slot_idx] = 1'b0;
                            end
                        end
                        ACT_SET_TIME:
                        begin
                            time_next = new_time;
                        end
                        default:
                        begin
                            // Unused codes change nothing
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                // Decrement the slot read last cycle; mark pending on reaching zero
                if (tick_dec)
                begin
                    cd_we = 1'b1;
                    if (cd_rdata == DATA_W'(1))
                    begin
                        pending_next[rd_idx_reg] = 1'b1;
                    end
                end
                if (tick_proc && rd_end_reg)
                begin
                    res_vld_next = 1'b1;
                end
            end
            S_RUN:
            begin
                if (run_hit)
                begin
                    pending_next[rd_idx_reg] = 1'b0;
                    if (rl_data == '0)
                    begin
                        active_next[rd_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        cd_we    = 1'b1;
                        cd_wdata = rl_data;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    // Release the previous hit now that another one follows
                    if (hold_vld_reg)
                    begin
                        res_vld_next = 1'b1;
                        fv_next      = 1'b1;
                        fslot_next   = hold_slot_reg;
                        ftag_next    = hold_tag_reg;
                        last_next    = 1'b0;
                    end
                    hold_vld_next  = 1'b1;
                    hold_slot_next = rd_slot4;
                    hold_tag_next  = tg_data;
                end
            end
            S_FLUSH:
            begin
                // Emit the held hit as final result, or an empty pass result
                res_vld_next  = 1'b1;
                fv_next       = hold_vld_reg;
                fslot_next    = hold_vld_reg ? hold_slot_reg : '0;
                ftag_next     = hold_vld_reg ? hold_tag_reg : '0;
                hold_vld_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            scan_done_reg <= 1'b1;
            rd_vld_reg    <= 1'b0;
            active_reg    <= '0;
            pending_reg   <= '0;
            time_reg      <= '0;
            cnt_reg       <= '0;
            hold_vld_reg  <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            scan_done_reg <= scan_done_next;
            rd_vld_reg    <= issue;
            active_reg    <= active_next;
            pending_reg   <= pending_next;
            time_reg      <= time_next;
            cnt_reg       <= cnt_next;
            hold_vld_reg  <= hold_vld_next;
            res_vld_reg   <= res_vld_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= scan_reg;
        rd_end_reg    <= (scan_reg == LAST_IDX);
        hold_slot_reg <= hold_slot_next;
        hold_tag_reg  <= hold_tag_next;
        status_reg    <= status_next;
        fv_reg        <= fv_next;
        fslot_reg     <= fslot_next;
        ftag_reg      <= ftag_next;
        last_reg      <= last_next;
    end

    assign result_valid = res_vld_reg;
    assign status       = status_reg;
    assign fired_valid  = fv_reg;
    assign fired_slot   = fslot_reg;
    assign fired_tag    = ftag_reg;
    assign time_now     = time_reg;
    assign last         = last_reg;

    // A pending mark never outlives its slot
    a_pending_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~active_reg) == '0)
        else $error("pending mark on a free slot");

    // A run pass never dispatches beyond the result limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("dispatch count beyond limit");

    // A non-dispatch result always closes its item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !fv_reg |-> last_reg)
        else $error("non-dispatch result not flagged last");

    // The final result of an item leaves the block ready for the next one
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && last_reg |-> state_reg == S_IDLE)
        else $error("final result while still sweeping");

    // Memory read data only arrives during a sweep
    a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> state_reg != S_IDLE)
        else $error("memory read outside a sweep");

endmodule
